// File: hw/rtl/u16u8b_pkg.sv
// ----------------------------------------------------------------------------
// u16u8b_pkg
// Shared constants, types and the UTF-8 character encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package u16u8b_pkg;

	// configuration register indexes
	localparam logic CFG_SOURCE_MODE  = 1'b0;
	localparam logic CFG_OUT_CAPACITY = 1'b1;

	// source_mode codes
	localparam logic MODE_UTF16  = 1'b0;
	localparam logic MODE_LATIN1 = 1'b1;

	localparam logic [15:0] SURR_MASK     = 16'hfc00;
	localparam logic [15:0] SURR_ANY_MASK = 16'hf800;
	localparam logic [15:0] SURR_HIGH     = 16'hd800;
	localparam logic [15:0] SURR_LOW      = 16'hdc00;

	localparam logic [20:0] CP_REPLACEMENT = 21'h00fffd;
	localparam logic [20:0] CP_SUPP_BASE   = 21'h010000;

	// one encoded character: len bytes, b[0] goes out first
	typedef struct packed {
		logic [2:0]      len;
		logic [3:0][7:0] b;
	} utf8_char_t;

	function automatic utf8_char_t utf8_encode(input logic [20:0] cp);
		utf8_char_t r;
		r.b = '0;
		if (cp < 21'h000080) begin
			r.len  = 3'd1;
			r.b[0] = cp[7:0];
		end else if (cp < 21'h000800) begin
			r.len  = 3'd2;
			r.b[0] = 8'hc0 | {3'b000, cp[10:6]};
			r.b[1] = 8'h80 | {2'b00, cp[5:0]};
		end else if (cp < CP_SUPP_BASE) begin
			r.len  = 3'd3;
			r.b[0] = 8'he0 | {4'b0000, cp[15:12]};
			r.b[1] = 8'h80 | {2'b00, cp[11:6]};
			r.b[2] = 8'h80 | {2'b00, cp[5:0]};
		end else begin
			r.len  = 3'd4;
			r.b[0] = 8'hf0 | {5'b00000, cp[20:18]};
			r.b[1] = 8'h80 | {2'b00, cp[17:12]};
			r.b[2] = 8'h80 | {2'b00, cp[11:6]};
			r.b[3] = 8'h80 | {2'b00, cp[5:0]};
		end
		return r;
	endfunction

endpackage

`default_nettype wire

// File: hw/rtl/utf16_latin1_to_utf8_bounded_unit.sv
// ----------------------------------------------------------------------------
// utf16_latin1_to_utf8_bounded_unit
// UTF-16 / Latin-1 to UTF-8 stream encoder with a bounded destination and an
// end-of-string count report.
// ----------------------------------------------------------------------------
// An accepted word is registered in the input register, then converted in one
// pass into the result buffer; a unit loads there as the last word of the one
// before is taken. Output: one word per cycle while m_tready is high; a unit
// causes 0 to 7 result words (up to six bytes and the report, three bytes for
// a typical BMP character). The one-byte result port sets this rate.
// Reset: arst_n clears config, string state and both valid stages at once.
`default_nettype none

module utf16_latin1_to_utf8_bounded_unit
	import u16u8b_pkg::*;
#(
	parameter int COUNT_WIDTH = 32
) (
	input  wire logic        clk,
	input  wire logic        arst_n,

	// configuration
	input  wire logic        cfg_we,
	input  wire logic        cfg_index,
	input  wire logic [31:0] cfg_data,

	// source units
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [15:0] s_tdata,   // [15:0] code_unit
	input  wire logic        s_tuser,   // [0] unit_present
	input  wire logic        s_tlast,   // last_unit

	// UTF-8 bytes and reports
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [71:0]      m_tdata,   // [7:0] out_byte, [39:8] units_read,
	                                    // [71:40] bytes_written
	output logic             m_tuser,   // [0] is_report
	output logic             m_tlast    // run_end
);

	localparam int CW = COUNT_WIDTH;
	localparam int XW = (CW > 32) ? CW : 32;   // room to extend or clip to 32

	// ---------------- configuration ----------------
	logic          mode_q;
	logic [CW-1:0] cap_q;      // capacity, already clipped to the counter range
	logic [XW-1:0] cfg_wide;
	logic [XW-1:0] cnt_max_wide;

	assign cfg_wide     = XW'(cfg_data);
	assign cnt_max_wide = XW'({CW{1'b1}});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_UTF16;
			cap_q  <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_SOURCE_MODE:  mode_q <= cfg_data[0];
				CFG_OUT_CAPACITY: cap_q  <= (cfg_wide > cnt_max_wide) ?
				                            {CW{1'b1}} : cfg_wide[CW-1:0];
				default: ;
			endcase
		end
	end

	// ---------------- input register ----------------
	logic        valid_s1;
	logic [15:0] unit_s1;
	logic        present_s1;
	logic        last_s1;
	logic        load;

	assign s_tready = !valid_s1 || load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			unit_s1    <= s_tdata;
			present_s1 <= s_tuser;
			last_s1    <= s_tlast;
		end
	end

	// ---------------- string state ----------------
	logic [9:0]    held_high_q;
	logic          held_valid_q;
	logic [CW-1:0] rc_q;       // units read
	logic [CW-1:0] wc_q;       // bytes written
	logic          halted_q;

	// ---------------- conversion pass ----------------
	// Up to two characters per unit: the first (c1) and a second one (d),
	// which is either a character from the unit itself or the end flush of
	// a held high surrogate.
	logic          c1_en, c2_en;
	logic [20:0]   c1_cp, c2_cp, d_cp;
	logic [1:0]    c1_units;
	logic          nhv;        // held surrogate after this unit, if c1 fits
	logic [9:0]    nhh;
	logic          is_hi, is_lo, is_surr;
	utf8_char_t    enc1, enc2;
	logic [2:0]    len1_g, len2;
	logic [CW:0]   wc_ext, cap_ext, sum1, sum2;
	logic          fit1, halt1, d_en, fit2, halt2;
	logic [2:0]    nd1, nd2, ndata;
	logic [1:0]    u1_g, uf_g;
	logic [CW-1:0] rc1, rcf, wc_n;
	logic [5:0][7:0] buf_n;

	assign is_hi   = (unit_s1 & SURR_MASK) == SURR_HIGH;
	assign is_lo   = (unit_s1 & SURR_MASK) == SURR_LOW;
	assign is_surr = (unit_s1 & SURR_ANY_MASK) == SURR_HIGH;

	always_comb begin
		c1_en    = 1'b0;
		c1_cp    = CP_REPLACEMENT;
		c1_units = 2'd1;
		c2_en    = 1'b0;
		c2_cp    = CP_REPLACEMENT;
		nhv      = held_valid_q;
		nhh      = held_high_q;
		if (present_s1 && !halted_q) begin
			if (mode_q == MODE_LATIN1) begin
				nhv   = 1'b0;
				c1_en = 1'b1;
				if (held_valid_q) begin
					// stale high surrogate goes out first
					c2_en = 1'b1;
					c2_cp = {13'd0, unit_s1[7:0]};
				end else begin
					c1_cp = {13'd0, unit_s1[7:0]};
				end
			end else if (held_valid_q) begin
				nhv   = 1'b0;
				c1_en = 1'b1;
				if (is_lo) begin
					c1_cp    = CP_SUPP_BASE + {1'b0, held_high_q, unit_s1[9:0]};
					c1_units = 2'd2;
				end else if (is_hi) begin
					nhv = 1'b1;
					nhh = unit_s1[9:0];
				end else if (is_surr) begin
					c2_en = 1'b1;
				end else begin
					c2_en = 1'b1;
					c2_cp = {5'd0, unit_s1};
				end
			end else begin
				if (is_hi) begin
					nhv = 1'b1;
					nhh = unit_s1[9:0];
				end else if (is_surr) begin
					c1_en = 1'b1;
				end else begin
					c1_en = 1'b1;
					c1_cp = {5'd0, unit_s1};
				end
			end
		end
	end

	assign d_cp = c2_en ? c2_cp : CP_REPLACEMENT;
	assign enc1 = utf8_encode(c1_cp);
	assign enc2 = utf8_encode(d_cp);

	assign len1_g  = c1_en ? enc1.len : 3'd0;
	assign len2    = enc2.len;
	assign wc_ext  = {1'b0, wc_q};
	assign cap_ext = {1'b0, cap_q};
	// both fit checks side by side; the second assumes the first fitted
	assign sum1    = wc_ext + (CW+1)'(len1_g);
	assign sum2    = wc_ext + (CW+1)'({1'b0, len1_g} + {1'b0, len2});
	assign fit1    = c1_en && (sum1 <= cap_ext);
	assign halt1   = c1_en && !fit1;
	assign d_en    = !halt1 && (c2_en || (last_s1 && nhv));
	assign fit2    = d_en && (sum2 <= cap_ext);
	assign halt2   = d_en && !fit2;

	assign nd1   = fit1 ? enc1.len : 3'd0;
	assign nd2   = fit2 ? len2 : 3'd0;
	assign ndata = nd1 + nd2;
	assign u1_g  = fit1 ? c1_units : 2'd0;
	assign uf_g  = u1_g + (fit2 ? 2'd1 : 2'd0);
	assign rc1   = rc_q + CW'(u1_g);
	assign rcf   = rc_q + CW'(uf_g);
	assign wc_n  = wc_q + CW'(ndata);

	// lay out the bytes of both characters back to back
	always_comb begin
		logic [2:0] idx;
		for (int k = 0; k < 6; k++) begin
			idx = 3'(k) - nd1;
			if (3'(k) < nd1) begin
				buf_n[k] = enc1.b[2'(k)];
			end else if (idx < 3'd4) begin
				buf_n[k] = enc2.b[idx[1:0]];
			end else begin
				buf_n[k] = 8'h00;
			end
		end
	end

	// ---------------- result buffer ----------------
	logic [5:0][7:0] byte_q;    // remaining data bytes, head at 0
	logic [2:0]      data_q;    // data bytes left
	logic [2:0]      c1_q;      // of those, still from the first character
	logic            rep_q;     // report still to send
	logic [CW-1:0]   units1_q;
	logic [CW-1:0]   unitsf_q;
	logic [CW-1:0]   bw_q;      // bytes_written of the head word
	logic            take;
	logic [CW-1:0]   units_cur;
	logic [XW-1:0]   units_wide, bw_wide;

	assign m_tvalid = (data_q != 3'd0) || rep_q;
	assign m_tuser  = (data_q == 3'd0);
	assign m_tlast  = ((data_q == 3'd1) && !rep_q) || ((data_q == 3'd0) && rep_q);
	assign take     = m_tvalid && m_tready;
	assign load     = valid_s1 && (!m_tvalid || (m_tready && m_tlast));

	assign units_cur  = (c1_q != 3'd0) ? units1_q : unitsf_q;
	assign units_wide = XW'(units_cur);
	assign bw_wide    = XW'(bw_q);
	assign m_tdata    = {bw_wide[31:0], units_wide[31:0],
	                     (data_q != 3'd0) ? byte_q[0] : 8'h00};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			data_q       <= '0;
			c1_q         <= '0;
			rep_q        <= 1'b0;
			held_high_q  <= '0;
			held_valid_q <= 1'b0;
			rc_q         <= '0;
			wc_q         <= '0;
			halted_q     <= 1'b0;
		end else if (load) begin
			data_q <= ndata;
			c1_q   <= nd1;
			rep_q  <= last_s1;
			if (last_s1) begin
				// report closes the string
				held_high_q  <= '0;
				held_valid_q <= 1'b0;
				rc_q         <= '0;
				wc_q         <= '0;
				halted_q     <= 1'b0;
			end else begin
				held_high_q  <= nhh;
				held_valid_q <= nhv && !halt1;
				rc_q         <= rcf;
				wc_q         <= wc_n;
				halted_q     <= halted_q || halt1 || halt2;
			end
		end else if (take) begin
			if (data_q != 3'd0) begin
				data_q <= data_q - 3'd1;
				c1_q   <= (c1_q != 3'd0) ? c1_q - 3'd1 : 3'd0;
			end else begin
				rep_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			byte_q   <= buf_n;
			units1_q <= rc1;
			unitsf_q <= rcf;
			bw_q     <= (ndata != 3'd0) ? wc_q + CW'(1) : wc_q;
		end else if (take && (data_q != 3'd0)) begin
			byte_q <= {8'h00, byte_q[5:1]};
			if (data_q > 3'd1) begin
				bw_q <= bw_q + CW'(1);
			end
		end
	end

	// ---------------- assertions ----------------
	// a halted string never keeps a surrogate waiting
	assert property (@(posedge clk) disable iff (!arst_n)
		halted_q |-> !held_valid_q)
		else $error("held surrogate while halted");

	// every character costs at least one byte per unit read
	assert property (@(posedge clk) disable iff (!arst_n)
		rc_q <= wc_q)
		else $error("units read exceed bytes written");

	// the report is always the final word of its unit
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser) |-> m_tlast)
		else $error("report not marked as run end");

	// first-character bytes are a prefix of the buffered bytes
	assert property (@(posedge clk) disable iff (!arst_n)
		c1_q <= data_q)
		else $error("first character count beyond buffer");

endmodule

`default_nettype wire
